// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker in ipbs_checker.sv.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IPBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipbs assertion failed");

// Next-cycle implication, disabled during reset.
`define IPBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipbs assertion failed");

`endif

// ===== sv/ipbs_pkg.sv =====
// Shared constants and types of the interval pair breakpoint splitter.
// No dependencies.
`timescale 1ns / 1ps

package ipbs_pkg;

    localparam int POS_W           = 31;
    localparam int TABLE_DEPTH_DEF = 63;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SPLIT  = 2'd2;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
        pos_t value;
    } chain_ctl_t;

endpackage

// ===== sv/ipbs_if.sv =====
// Valid/ready channel interfaces for input items and result pieces.
// Depends on ipbs_pkg.
`timescale 1ns / 1ps

interface ipbs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    ipbs_pkg::pos_t     breakpoint;
    logic               main_side;
    logic               inverted;
    ipbs_pkg::pos_t     first_start;
    ipbs_pkg::pos_t     first_end;
    ipbs_pkg::pos_t     second_start;
    ipbs_pkg::pos_t     second_end;

    modport source (output valid, operation, breakpoint, main_side, inverted,
                    first_start, first_end, second_start, second_end,
                    input ready);
    modport sink (input valid, operation, breakpoint, main_side, inverted,
                  first_start, first_end, second_start, second_end,
                  output ready);
endinterface

interface ipbs_out_if;
    logic               valid;
    logic               ready;
    ipbs_pkg::pos_t     piece_first_start;
    ipbs_pkg::pos_t     piece_first_end;
    ipbs_pkg::pos_t     piece_second_start;
    ipbs_pkg::pos_t     piece_second_end;
    logic               piece_inverted;
    logic               malformed;
    logic               table_overflowed;
    logic               last;

    modport source (output valid, piece_first_start, piece_first_end,
                    piece_second_start, piece_second_end, piece_inverted,
                    malformed, table_overflowed, last,
                    input ready);
    modport sink (input valid, piece_first_start, piece_first_end,
                  piece_second_start, piece_second_end, piece_inverted,
                  malformed, table_overflowed, last,
                  output ready);
endinterface

// ===== sv/ipbs_cell.sv =====
// One cell of the sorted breakpoint chain: a value and its valid bit.
// Depends on ipbs_pkg.
`timescale 1ns / 1ps

module ipbs_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ipbs_pkg::chain_ctl_t ctl,
    input  ipbs_pkg::pos_t       head_val,
    input  ipbs_pkg::pos_t       left_val,
    input  logic                 left_valid,
    input  logic                 left_gt,
    input  ipbs_pkg::pos_t       right_val,
    input  logic                 right_valid,
    output ipbs_pkg::pos_t       val,
    output logic                 valid,
    output logic                 gt
);

    ipbs_pkg::pos_t val_reg;
    ipbs_pkg::pos_t val_next;
    logic           valid_reg;
    logic           valid_next;
    logic           moves;

    // Cells holding a larger value shift right; the first empty cell fills.
    assign gt    = valid_reg && (val_reg > ctl.value);
    assign moves = gt || (!valid_reg && left_valid);

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.insert)
        begin
            if (moves)
            begin
                val_next   = left_gt ? left_val : ctl.value;
                valid_next = 1'b1;
            end
        end
        else if (ctl.rotate)
        begin
            // Advance toward the head; the last valid cell takes the head back.
            val_next = right_valid ? right_val : head_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

// ===== sv/ipbs_chain.sv =====
// Row of breakpoint cells with the entry count; head cell feeds the scan.
// Depends on ipbs_pkg and ipbs_cell.
`timescale 1ns / 1ps

module ipbs_chain #(
    parameter int TABLE_DEPTH = ipbs_pkg::TABLE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ipbs_pkg::chain_ctl_t ctl,
    output ipbs_pkg::pos_t       head,
    output logic [CNT_W-1:0]     count,
    output logic                 full
);

    ipbs_pkg::pos_t   vals   [TABLE_DEPTH];
    logic             valids [TABLE_DEPTH];
    logic             gts    [TABLE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            ipbs_pkg::pos_t lv;
            logic           lvd;
            logic           lgt;
            ipbs_pkg::pos_t rv;
            logic           rvd;

            if (i == 0)
            begin : g_first
                assign lv  = ctl.value;
                assign lvd = 1'b1;
                assign lgt = 1'b0;
            end
            else
            begin : g_mid
                assign lv  = vals[i-1];
                assign lvd = valids[i-1];
                assign lgt = gts[i-1];
            end

            if (i == TABLE_DEPTH - 1)
            begin : g_last
                assign rv  = vals[0];
                assign rvd = 1'b0;
            end
            else
            begin : g_inner
                assign rv  = vals[i+1];
                assign rvd = valids[i+1];
            end

            ipbs_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .head_val    (vals[0]),
                .left_val    (lv),
                .left_valid  (lvd),
                .left_gt     (lgt),
                .right_val   (rv),
                .right_valid (rvd),
                .val         (vals[i]),
                .valid       (valids[i]),
                .gt          (gts[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = vals[0];
    assign count = count_reg;
    assign full  = (count_reg == CNT_W'(TABLE_DEPTH));

endmodule

// ===== sv/interval_pair_breakpoint_splitter.sv =====
// Clear and insert act on acceptance; an insert shifts the chain in place.
// A split is accepted, then rotates the table through the chain
// head one cell per cycle: entry_count scan steps plus one tail step for the remainder,
// giving at most one piece per cycle.
// Each piece is registered on a cut or in the tail step; output stalls hold the scan.
// Reset clears entry count, valid bits, overflow flag and control; table values stay.
`timescale 1ns / 1ps

module interval_pair_breakpoint_splitter #(
    parameter int TABLE_DEPTH = ipbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ipbs_in_if.sink    in_ch,
    ipbs_out_if.source out_ch
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CNT_W-1:0]     step_reg;
    logic [CNT_W-1:0]     step_next;
    logic                 ovf_reg;
    logic                 ovf_next;

    // Split context
    logic                 main_reg;
    logic                 inv_reg;
    ipbs_pkg::pos_t       lo_reg;
    ipbs_pkg::pos_t       hi_reg;
    ipbs_pkg::pos_t       esec_reg;
    ipbs_pkg::pos_t       delta_reg;
    ipbs_pkg::pos_t       dm1_reg;
    ipbs_pkg::pos_t       curm_reg;
    ipbs_pkg::pos_t       cursec_reg;

    // Output register
    logic                 ovalid_reg;
    ipbs_pkg::pos_t       ofs_reg;
    ipbs_pkg::pos_t       ofe_reg;
    ipbs_pkg::pos_t       oss_reg;
    ipbs_pkg::pos_t       ose_reg;
    logic                 oinv_reg;
    logic                 omal_reg;
    logic                 oovf_reg;
    logic                 olast_reg;

    ipbs_pkg::chain_ctl_t ctl;
    ipbs_pkg::pos_t       head;
    logic [CNT_W-1:0]     count;
    logic                 full;

    logic                 in_acc;
    logic                 step_en;
    logic                 cut;
    logic                 load;
    ipbs_pkg::pos_t       pe_m;
    ipbs_pkg::pos_t       pe_sec;
    ipbs_pkg::pos_t       ps_m;
    ipbs_pkg::pos_t       ps_sec;
    ipbs_pkg::pos_t       pend_m;
    ipbs_pkg::pos_t       pend_sec;
    ipbs_pkg::pos_t       in_sm;
    ipbs_pkg::pos_t       in_ssec;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign step_en     = !ovalid_reg || out_ch.ready;

    assign in_sm   = in_ch.main_side ? in_ch.second_start : in_ch.first_start;
    assign in_ssec = in_ch.main_side ? in_ch.first_start : in_ch.second_start;

    // Both sides advance equally, so the start offset is fixed for the split.
    assign cut    = (head >= lo_reg) && (head <= hi_reg) && (head != curm_reg);
    assign pe_m   = head - ipbs_pkg::pos_t'(1);
    assign pe_sec = head + dm1_reg;

    always_comb
    begin
        if (state_reg == ST_TAIL)
        begin
            ps_m     = curm_reg;
            ps_sec   = cursec_reg;
            pend_m   = hi_reg;
            pend_sec = esec_reg;
        end
        else
        begin
            ps_m     = curm_reg;
            ps_sec   = cursec_reg;
            pend_m   = pe_m;
            pend_sec = pe_sec;
        end
    end

    assign load = step_en && ((state_reg == ST_TAIL) || ((state_reg == ST_SCAN) && cut));

    always_comb
    begin
        ctl.clear  = in_acc && (in_ch.operation == ipbs_pkg::OP_CLEAR);
        ctl.insert = in_acc && (in_ch.operation == ipbs_pkg::OP_INSERT) && !full;
        ctl.rotate = (state_reg == ST_SCAN) && step_en;
        ctl.value  = in_ch.breakpoint;
    end

    always_comb
    begin
        ovf_next = ovf_reg;
        if (ctl.clear)
        begin
            ovf_next = 1'b0;
        end
        else if (in_acc && (in_ch.operation == ipbs_pkg::OP_INSERT) && full)
        begin
            ovf_next = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_ch.operation == ipbs_pkg::OP_SPLIT))
                begin
                    step_next  = '0;
                    state_next = (count == '0) ? ST_TAIL : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_en)
                begin
                    step_next = step_reg + CNT_W'(1);
                    if ((step_reg + CNT_W'(1)) == count)
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL:
            begin
                if (step_en)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ovf_reg   <= ovf_next;
            if (load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (in_ch.operation == ipbs_pkg::OP_SPLIT))
        begin
            main_reg   <= in_ch.main_side;
            inv_reg    <= in_ch.inverted;
            lo_reg     <= in_sm;
            hi_reg     <= in_ch.main_side ? in_ch.second_end : in_ch.first_end;
            esec_reg   <= in_ch.main_side ? in_ch.first_end : in_ch.second_end;
            delta_reg  <= in_ssec - in_sm;
            dm1_reg    <= in_ssec + ~in_sm;
            curm_reg   <= in_sm;
            cursec_reg <= in_ssec;
        end
        else if ((state_reg == ST_SCAN) && step_en && cut)
        begin
            curm_reg   <= head;
            cursec_reg <= head + delta_reg;
        end

        if (load)
        begin
            ofs_reg   <= main_reg ? ps_sec : ps_m;
            ofe_reg   <= main_reg ? pend_sec : pend_m;
            oss_reg   <= main_reg ? ps_m : ps_sec;
            ose_reg   <= main_reg ? pend_m : pend_sec;
            oinv_reg  <= inv_reg;
            omal_reg  <= (ps_m > pend_m) || (ps_sec > pend_sec);
            oovf_reg  <= ovf_reg;
            olast_reg <= (state_reg == ST_TAIL);
        end
    end

    ipbs_chain #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .head  (head),
        .count (count),
        .full  (full)
    );

    assign out_ch.valid              = ovalid_reg;
    assign out_ch.piece_first_start  = ofs_reg;
    assign out_ch.piece_first_end    = ofe_reg;
    assign out_ch.piece_second_start = oss_reg;
    assign out_ch.piece_second_end   = ose_reg;
    assign out_ch.piece_inverted     = oinv_reg;
    assign out_ch.malformed          = omal_reg;
    assign out_ch.table_overflowed   = oovf_reg;
    assign out_ch.last               = olast_reg;

endmodule

// ===== sv/ipbs_checker.sv =====
// Port-level checks of the splitter, bound to the top level.
// Depends on ipbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_operation,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_last
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // A stalled piece stays offered.
    `IPBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // An accepted split keeps the block busy, so input is not ready right after it.
    `IPBS_ASSERT_NEXT(a_split_busy, clk, rst_n, in_acc && (in_operation == ipbs_pkg::OP_SPLIT), !in_ready)
    // While a piece other than the final one is offered, no new item is taken.
    `IPBS_ASSERT_NOW(a_mid_split_busy, clk, rst_n, out_valid && !out_last, !in_ready)
    // Clear and insert give no piece.
    `IPBS_ASSERT_NEXT(a_no_piece, clk, rst_n, in_acc && !out_valid && (in_operation != ipbs_pkg::OP_SPLIT), !out_valid)

endmodule

bind interval_pair_breakpoint_splitter ipbs_checker u_ipbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_last     (out_ch.last)
);

// ===== bench/split_piece_checker.sv =====
// Checker for the interval pair breakpoint splitter: mirrors the breakpoint table and
// predicts the pieces of every split, then compares each piece the block hands out.
// Depends on ipbs_pkg and the channel interfaces in ipbs_if.
`timescale 1ns / 1ps

module split_piece_checker #(
    parameter int DEPTH = ipbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ipbs_in_if   in_ch,
    ipbs_out_if  out_ch,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        ipbs_pkg::pos_t first_start;
        ipbs_pkg::pos_t first_end;
        ipbs_pkg::pos_t second_start;
        ipbs_pkg::pos_t second_end;
        logic           inverted;
        logic           malformed;
        logic           overflowed;
        logic           last;
    } piece_t;

    ipbs_pkg::pos_t bp_table [DEPTH];
    int unsigned    n_entries = 0;
    logic           overflowed = 1'b0;
    piece_t         pieces_due [$];
    int             bad_count = 0;
    int             due_count = 0;

    assign mismatches  = bad_count;
    assign outstanding = due_count;

    // Full table drops the value and latches the overflow flag.
    function automatic void insert_sorted(ipbs_pkg::pos_t v);
        int unsigned slot;
        int unsigned i;
        if (n_entries >= DEPTH) begin
            overflowed = 1'b1;
            return;
        end
        slot = 0;
        while (slot < n_entries && bp_table[slot] <= v)
            slot++;
        for (i = n_entries; i > slot; i--)
            bp_table[i] = bp_table[i - 1];
        bp_table[slot] = v;
        n_entries++;
    endfunction

    function automatic void queue_piece(ipbs_pkg::pos_t st [2], ipbs_pkg::pos_t en [2],
                                        logic inv, logic fin);
        piece_t p;
        p.first_start  = st[0];
        p.first_end    = en[0];
        p.second_start = st[1];
        p.second_end   = en[1];
        p.inverted     = inv;
        p.malformed    = (st[0] > en[0]) || (st[1] > en[1]);
        p.overflowed   = overflowed;
        p.last         = fin;
        pieces_due     = {pieces_due, p};
    endfunction

    // Cut the pair at every breakpoint inside the main interval; both sides advance
    // together, all position math wraps at 31 bits.
    function automatic void split_pair(logic m, logic inv, ipbs_pkg::pos_t fs,
                                       ipbs_pkg::pos_t fe, ipbs_pkg::pos_t ss,
                                       ipbs_pkg::pos_t se);
        ipbs_pkg::pos_t st [2];
        ipbs_pkg::pos_t en [2];
        ipbs_pkg::pos_t ps [2];
        ipbs_pkg::pos_t pe [2];
        ipbs_pkg::pos_t lo, hi, bp, adv;
        logic           sec;
        int unsigned    i;
        sec   = ~m;
        st[0] = fs;
        en[0] = fe;
        st[1] = ss;
        en[1] = se;
        lo    = st[m];
        hi    = en[m];
        for (i = 0; i < n_entries; i++) begin
            bp = bp_table[i];
            if (bp < lo || bp > hi || bp == st[m])
                continue;
            ps      = st;
            pe      = en;
            adv     = bp - st[m];
            st[sec] = st[sec] + adv;
            st[m]   = bp;
            pe[m]   = st[m] - ipbs_pkg::pos_t'(1);
            pe[sec] = st[sec] - ipbs_pkg::pos_t'(1);
            queue_piece(ps, pe, inv, 1'b0);
        end
        queue_piece(st, en, inv, 1'b1);
    endfunction

    task automatic check_field(string name, ipbs_pkg::pos_t want, ipbs_pkg::pos_t got);
        if (want !== got) begin
            bad_count++;
            $display("[%0t] piece %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        piece_t want;
        if (!rst_n)
        begin
            n_entries  = 0;
            overflowed = 1'b0;
            pieces_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.operation)
                    ipbs_pkg::OP_CLEAR:
                    begin
                        n_entries  = 0;
                        overflowed = 1'b0;
                    end
                    ipbs_pkg::OP_INSERT: insert_sorted(in_ch.breakpoint);
                    ipbs_pkg::OP_SPLIT:  split_pair(in_ch.main_side, in_ch.inverted,
                                                    in_ch.first_start, in_ch.first_end,
                                                    in_ch.second_start, in_ch.second_end);
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pieces_due.size() == 0)
                begin
                    bad_count++;
                    $display({"[%0t] piece: expected none, got %h %h %h %h",
                              " inv=%b mal=%b ovf=%b last=%b"},
                             $time, out_ch.piece_first_start, out_ch.piece_first_end,
                             out_ch.piece_second_start, out_ch.piece_second_end,
                             out_ch.piece_inverted, out_ch.malformed,
                             out_ch.table_overflowed, out_ch.last);
                end
                else
                begin
                    want = pieces_due.pop_front();
                    check_field("first_start", want.first_start, out_ch.piece_first_start);
                    check_field("first_end", want.first_end, out_ch.piece_first_end);
                    check_field("second_start", want.second_start,
                                out_ch.piece_second_start);
                    check_field("second_end", want.second_end, out_ch.piece_second_end);
                    check_field("inverted", ipbs_pkg::pos_t'(want.inverted),
                                ipbs_pkg::pos_t'(out_ch.piece_inverted));
                    check_field("malformed", ipbs_pkg::pos_t'(want.malformed),
                                ipbs_pkg::pos_t'(out_ch.malformed));
                    check_field("overflowed", ipbs_pkg::pos_t'(want.overflowed),
                                ipbs_pkg::pos_t'(out_ch.table_overflowed));
                    check_field("last", ipbs_pkg::pos_t'(want.last),
                                ipbs_pkg::pos_t'(out_ch.last));
                end
            end
            due_count <= pieces_due.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the splitter bench: clock, reset, stimulus with bursty input and stalling output.
// Depends on ipbs_pkg, ipbs_if, the splitter RTL and split_piece_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 420;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   items_sent;
    int   burst_left;
    bit   valid_held;
    int   stall_mode;
    int   mode_left;
    int   cycle_count;

    ipbs_in_if  in_ch ();
    ipbs_out_if out_ch ();

    interval_pair_breakpoint_splitter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    split_piece_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic ipbs_pkg::pos_t rand_pos();
        return ipbs_pkg::pos_t'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Receiver: switch between always-ready, coin-flip, heavy stall and a fixed pattern.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            mode_left  = $urandom_range(50, 300);
            stall_mode = $urandom_range(0, 3);
        end
        else
            mode_left--;
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= rand_bit();
            2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= (cycle_count % 5 != 2) && (cycle_count % 7 != 0);
        endcase
    end

    // Present one item, hold it until taken, then maybe open an idle gap.
    task automatic send_item(logic [1:0] op, ipbs_pkg::pos_t bp, logic m, logic inv,
                             ipbs_pkg::pos_t fs, ipbs_pkg::pos_t fe,
                             ipbs_pkg::pos_t ss, ipbs_pkg::pos_t se);
        int idle_gap;
        in_ch.operation    <= op;
        in_ch.breakpoint   <= bp;
        in_ch.main_side    <= m;
        in_ch.inverted     <= inv;
        in_ch.first_start  <= fs;
        in_ch.first_end    <= fe;
        in_ch.second_start <= ss;
        in_ch.second_end   <= se;
        in_ch.valid        <= 1'b1;
        valid_held = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        if (op != OP_UNUSED)
            items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            idle_gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 5);
            if ($urandom_range(0, 5) != 0)
            begin
                in_ch.valid <= 1'b0;
                valid_held = 1'b0;
                repeat (idle_gap) @(posedge clk);
            end
        end
    endtask

    // Hold off input until every predicted piece has come out.
    task automatic wait_drained();
        if (valid_held)
        begin
            in_ch.valid <= 1'b0;
            valid_held = 1'b0;
        end
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        ipbs_pkg::pos_t base, ms, me, ss, se, len, tmp;
        logic m;
        int   n_ins, n_split, target;
        bit   first_phase;

        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.operation    = ipbs_pkg::OP_CLEAR;
        in_ch.breakpoint   = '0;
        in_ch.main_side    = 1'b0;
        in_ch.inverted     = 1'b0;
        in_ch.first_start  = '0;
        in_ch.first_end    = '0;
        in_ch.second_start = '0;
        in_ch.second_end   = '0;
        items_sent = 0;
        burst_left = 0;
        valid_held = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: the pair comes back whole as the last piece.
        send_item(ipbs_pkg::OP_SPLIT, 31'h7FFF_FFFF, 1'b0, 1'b0, '0, 31'h7FFF_FFFF,
                  '0, 31'h7FFF_FFFF);
        send_item(OP_UNUSED, rand_pos(), 1'b1, 1'b1, rand_pos(), rand_pos(),
                  rand_pos(), rand_pos());
        // Duplicates, both extremes, out-of-order inserts.
        send_item(ipbs_pkg::OP_INSERT, 31'd100, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(ipbs_pkg::OP_INSERT, 31'd100, 1'b1, 1'b1, '0, '0, '0, '0);
        send_item(ipbs_pkg::OP_INSERT, 31'd50, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(ipbs_pkg::OP_INSERT, 31'd0, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(ipbs_pkg::OP_INSERT, 31'h7FFF_FFFF, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(ipbs_pkg::OP_INSERT, 31'd300, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(ipbs_pkg::OP_SPLIT, '0, 1'b0, 1'b1, 31'd0, 31'd200, 31'd1000, 31'd1200);
        // Main on the second side; the first side wraps past the top.
        send_item(ipbs_pkg::OP_SPLIT, '0, 1'b1, 1'b0, 31'h7FFF_FF00, 31'h7FFF_FECD,
                  31'd50, 31'h7FFF_FFFF);
        // Start above end on both sides.
        send_item(ipbs_pkg::OP_SPLIT, '0, 1'b0, 1'b1, 31'd300, 31'd100, 31'd5, 31'd3);
        // Single-position interval sitting on a breakpoint: no cut.
        send_item(ipbs_pkg::OP_SPLIT, '0, 1'b1, 1'b0, 31'd7, 31'd7, 31'd100, 31'd100);
        wait_drained();
        send_item(ipbs_pkg::OP_CLEAR, '0, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(ipbs_pkg::OP_SPLIT, '0, 1'b1, 1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF);

        target = items_sent + RANDOM_ITEMS;
        first_phase = 1'b1;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 1) == 0)
                send_item(ipbs_pkg::OP_CLEAR, rand_pos(), rand_bit(), rand_bit(),
                          rand_pos(), rand_pos(), rand_pos(), rand_pos());
            case ($urandom_range(0, 3))
                0:       base = ipbs_pkg::pos_t'($urandom_range(0, 2000));
                1:       base = 31'h7FFF_FFFF - ipbs_pkg::pos_t'($urandom_range(0, 600));
                default: base = rand_pos();
            endcase
            // Now and then run the table past full.
            if (first_phase || $urandom_range(0, 9) == 0)
                n_ins = $urandom_range(60, 70);
            else
                n_ins = $urandom_range(0, 8);
            first_phase = 1'b0;
            repeat (n_ins)
            begin
                if ($urandom_range(0, 7) == 0)
                    tmp = rand_pos();
                else
                    tmp = base + ipbs_pkg::pos_t'($urandom_range(0, 400));
                send_item(ipbs_pkg::OP_INSERT, tmp, rand_bit(), rand_bit(),
                          rand_pos(), rand_pos(), rand_pos(), rand_pos());
            end
            n_split = $urandom_range(1, 5);
            repeat (n_split)
            begin
                m   = rand_bit();
                ms  = ($urandom_range(0, 7) == 0)
                      ? rand_pos()
                      : ipbs_pkg::pos_t'(base + ipbs_pkg::pos_t'($urandom_range(0, 300)));
                len = ($urandom_range(0, 7) == 0) ? rand_pos()
                                                  : ipbs_pkg::pos_t'($urandom_range(0, 500));
                me  = ms + len;
                ss  = ($urandom_range(0, 3) == 0)
                      ? ipbs_pkg::pos_t'(31'h7FFF_FFFF - $urandom_range(0, 200))
                      : rand_pos();
                se  = ($urandom_range(0, 9) == 0) ? rand_pos() : ipbs_pkg::pos_t'(ss + len);
                if ($urandom_range(0, 9) == 0)
                begin
                    tmp = ms;
                    ms  = me;
                    me  = tmp;
                end
                if (m)
                    send_item(ipbs_pkg::OP_SPLIT, rand_pos(), m, rand_bit(), ss, se, ms, me);
                else
                    send_item(ipbs_pkg::OP_SPLIT, rand_pos(), m, rand_bit(), ms, me, ss, se);
            end
            if ($urandom_range(0, 19) == 0)
                send_item(OP_UNUSED, rand_pos(), rand_bit(), rand_bit(),
                          rand_pos(), rand_pos(), rand_pos(), rand_pos());
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ipbs_pkg.sv
sv/ipbs_if.sv
sv/ipbs_cell.sv
sv/ipbs_chain.sv
sv/interval_pair_breakpoint_splitter.sv
sv/ipbs_checker.sv
bench/split_piece_checker.sv
bench/tb_top.sv
